// ===== sv/bset_pkg.sv =====
// Shared types and codes for the bounded set core.
// Used by bset_cell and bounded_set_insert_remove_lookup_core; no dependencies.
`default_nettype none

package bset_pkg;

  localparam int MODE_BITS  = 2;
  localparam int COUNT_BITS = 5;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_COMMIT
  } state_t;

  // Control part of the query token that walks along the cell row.
  typedef struct packed {
    logic                 valid;
    logic [MODE_BITS-1:0] mode;
    logic                 hit;
    logic                 free_found;
  } tok_ctl_t;

endpackage

`default_nettype wire

// ===== sv/bset_cell.sv =====
// One storage cell of the set: holds one value and its valid bit, checks the
// passing query token against them and hands the token on. Uses bset_pkg.
`default_nettype none

module bset_cell #(
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = 4,
  parameter int CELL_INDEX = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire bset_pkg::tok_ctl_t      ctl_in,
  input  wire logic [VALUE_BITS-1:0]   value_in,
  input  wire logic [IDX_W-1:0]        idx_in,
  output bset_pkg::tok_ctl_t           ctl_out,
  output logic      [VALUE_BITS-1:0]   value_out,
  output logic      [IDX_W-1:0]        idx_out,
  input  wire logic                    wr_en,
  input  wire logic [IDX_W-1:0]        wr_idx,
  input  wire logic [VALUE_BITS-1:0]   wr_value
);
  import bset_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic [VALUE_BITS-1:0] value;
  logic                  valid;
  logic                  match;
  logic                  wr_here;

  assign match   = valid && (value == value_in);
  assign wr_here = wr_en && (wr_idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_here) begin
      valid <= 1'b1;
    end else if (ctl_in.valid && ctl_in.mode == MODE_REMOVE && match) begin
      // Values are distinct, so at most one cell clears here.
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      value <= wr_value;
    end
  end

  // The first free cell seen along the row is the one an insert will take.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.mode       <= ctl_in.mode;
    ctl_out.hit        <= ctl_in.hit | match;
    ctl_out.free_found <= ctl_in.free_found | ~valid;
    value_out          <= value_in;
    idx_out            <= ctl_in.free_found ? idx_in : MY_IDX;
  end

endmodule

`default_nettype wire

// ===== sv/bounded_set_insert_remove_lookup_core.sv =====
// Top level of the bounded set: a row of bset_cell instances walked by one
// query token, plus the sequencer that commits inserts and counts. Uses bset_pkg.
//
//   channel | signals                                   | direction
//   input   | in_valid, in_ready, mode, item_value      | into the core
//   output  | out_valid, out_ready, op_ok, member_count, | out of the core
//           | set_empty, full_reject                    |
//
// An accepted operation walks the row one cell per cycle; the token leaving the
// last cell is captured in the finish register, and the result is registered at
// commit. No new operation is taken while one walks the row.
// A new operation is taken as soon as the previous one has committed, even while
// its result still waits in the output register. A stalled output holds the
// next commit only. Reset clears all valid bits and the count at once.
`default_nettype none

module bounded_set_insert_remove_lookup_core #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [bset_pkg::MODE_BITS-1:0]     mode,
  input  wire logic [31:0]                        item_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    op_ok,
  output logic      [bset_pkg::COUNT_BITS-1:0]    member_count,
  output logic                                    set_empty,
  output logic                                    full_reject
);
  import bset_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t state, state_next;

  tok_ctl_t              ctl_chain   [0:CAPACITY];
  logic [VALUE_BITS-1:0] value_chain [0:CAPACITY];
  logic [IDX_W-1:0]      idx_chain   [0:CAPACITY];
  logic [CAPACITY-1:0]   tok_live;

  tok_ctl_t              fin;
  logic [VALUE_BITS-1:0] fin_value;
  logic [IDX_W-1:0]      fin_idx;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [31:0]           count_wide;
  logic [63:0]           value_wide;
  logic                  commit;
  logic                  res_ok;
  logic                  res_reject;
  logic                  wr_en;

  // Only the low VALUE_BITS bits of the input value take part.
  assign value_wide = 64'(item_value);

  always_comb begin
    ctl_chain[0].valid      = in_valid && in_ready;
    ctl_chain[0].mode       = mode;
    ctl_chain[0].hit        = 1'b0;
    ctl_chain[0].free_found = 1'b0;
    value_chain[0]          = value_wide[VALUE_BITS-1:0];
    idx_chain[0]            = '0;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bset_cell #(
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W),
      .CELL_INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl_in    (ctl_chain[i]),
      .value_in  (value_chain[i]),
      .idx_in    (idx_chain[i]),
      .ctl_out   (ctl_chain[i+1]),
      .value_out (value_chain[i+1]),
      .idx_out   (idx_chain[i+1]),
      .wr_en     (wr_en),
      .wr_idx    (fin_idx),
      .wr_value  (fin_value)
    );
    assign tok_live[i] = ctl_chain[i+1].valid;
  end

  // Result of the finished walk.
  always_comb begin
    res_ok     = 1'b0;
    res_reject = 1'b0;
    count_next = count;
    case (fin.mode)
      MODE_INSERT: begin
        if (!fin.hit) begin
          if (fin.free_found) begin
            res_ok     = 1'b1;
            count_next = count + CNT_W'(1);
          end else begin
            res_reject = 1'b1;
          end
        end
      end
      MODE_REMOVE: begin
        if (fin.hit) begin
          res_ok     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      MODE_LOOKUP: begin
        res_ok = fin.hit;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  assign count_wide = 32'(count_next);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (ctl_chain[CAPACITY].valid) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_WALK:   in_ready = 1'b0;
      ST_COMMIT: commit   = !out_valid || out_ready;
      default:   in_ready = 1'b0;
    endcase
  end

  assign wr_en = commit && fin.mode == MODE_INSERT && !fin.hit && fin.free_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WALK && ctl_chain[CAPACITY].valid) begin
      fin       <= ctl_chain[CAPACITY];
      fin_value <= value_chain[CAPACITY];
      fin_idx   <= idx_chain[CAPACITY];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      op_ok        <= res_ok;
      full_reject  <= res_reject;
      member_count <= count_wide[COUNT_BITS-1:0];
      set_empty    <= (count_next == '0);
    end
  end

  // Only one query is ever in flight along the row.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_live))
    else $error("more than one query token in the cell row");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("held count exceeds capacity");

  a_tail_in_walk: assert property (@(posedge clk) disable iff (rst)
    ctl_chain[CAPACITY].valid |-> state == ST_WALK)
    else $error("query token left the row outside the walk state");

  a_accept_walks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_WALK && ctl_chain[1].valid)
    else $error("accepted operation did not enter the row");

  a_ok_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(op_ok && full_reject))
    else $error("result both succeeded and was rejected");

endmodule

`default_nettype wire
